// ----- hw/rtl/ipbst_pkg.sv -----
// Package for the IPv4 block set table: sizes, mode codes and the response flags struct.
// No dependencies.
package ipbst_pkg;
	localparam int CAPACITY_DEF = 256;
	localparam int ADDR_W = 32;
	localparam int MODE_W = 2;
	localparam int COUNT_W = 9;

	localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic present;
		logic changed;
		logic full_drop;
	} flags_t;
endpackage

// ----- hw/rtl/ipbst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ipbst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/ipv4_block_set_table_unit.sv -----
// IPv4 block set table top level: sequential scan of a slot RAM holding valid and address.
// A request is answered after one sweep of the RAM, one slot a cycle; the unit takes no
// new request until the response has been taken and it is back in idle.
// Reset clears count and control at once, then a clearing pass over the slot RAM
// marks every slot free; in_ready stays low until it ends.
// Depends on ipbst_pkg and ipbst_ram.
module ipv4_block_set_table_unit
	import ipbst_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [MODE_W-1:0]  mode,
	input  logic [ADDR_W-1:0]  address,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               present,
	output logic               changed,
	output logic               full_drop,
	output logic [COUNT_W-1:0] entry_count
);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int RAM_W = ADDR_W + 1;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_LAST = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;

	logic [2:0]          state_q;
	logic [MODE_W-1:0]   mode_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [IDX_W-1:0]    ridx_q;
	logic [IDX_W-1:0]    cidx_q;
	logic                rd_act_q;
	logic [CNT_W-1:0]    count_q;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic [RAM_W-1:0]    wdata;
	logic [RAM_W-1:0]    rdata;
	flags_t              flags_q;

	ipbst_ram #(.WIDTH(RAM_W), .DEPTH(CAPACITY)) u_slot_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(ridx_q), .rdata(rdata)
	);

	assign in_ready = (state_q == ST_IDLE) && !out_valid;
	assign we = (state_q == ST_CLEAR) ||
		((state_q == ST_DONE) &&
		 (((mode_q == MODE_ADD) && !hit_q && free_q) || ((mode_q == MODE_REMOVE) && hit_q)));
	assign waddr = (state_q == ST_CLEAR) ? ridx_q : (hit_q ? hit_idx_q : free_idx_q);
	assign wdata = (state_q == ST_CLEAR) ? '0 : {(mode_q == MODE_ADD), addr_q};
	assign present = flags_q.present;
	assign changed = flags_q.changed;
	assign full_drop = flags_q.full_drop;
	assign entry_count = COUNT_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid <= 1'b0;
			count_q <= '0;
			rd_act_q <= 1'b0;
			ridx_q <= '0;
			cidx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			rd_act_q <= 1'b0;
			if (rd_act_q) begin
				if (rdata[ADDR_W] && rdata[ADDR_W-1:0] == addr_q && !hit_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= cidx_q;
				end
				if (!rdata[ADDR_W] && !free_q) begin
					free_q <= 1'b1;
					free_idx_q <= cidx_q;
				end
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (ridx_q == IDX_W'(CAPACITY - 1)) begin
						ridx_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						ridx_q <= ridx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						mode_q <= mode;
						addr_q <= address;
						ridx_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_act_q <= 1'b1;
					cidx_q <= ridx_q;
					if (ridx_q == IDX_W'(CAPACITY - 1)) begin
						state_q <= ST_LAST;
					end else begin
						ridx_q <= ridx_q + 1'b1;
					end
				end
				ST_LAST: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					flags_q.present <= hit_q;
					flags_q.changed <= 1'b0;
					flags_q.full_drop <= 1'b0;
					if (mode_q == MODE_ADD && !hit_q) begin
						if (free_q) begin
							count_q <= count_q + 1'b1;
							flags_q.changed <= 1'b1;
						end else begin
							flags_q.full_drop <= 1'b1;
						end
					end else if (mode_q == MODE_REMOVE && hit_q) begin
						if (count_q != '0) begin
							count_q <= count_q - 1'b1;
						end
						flags_q.changed <= 1'b1;
					end
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- verif/tb.sv -----
// Testbench for ipv4_block_set_table_unit: directed runs (fill, overflow, removal), then random requests.
// Keeps its own copy of the address set and checks each response field by field.
// Depends on ipbst_pkg and the block's RTL.
module tb;
	import ipbst_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = CAPACITY_DEF;
	localparam int LATENCY = CAP + 3;
	localparam int WATCHDOG = 40 * LATENCY;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ADDR_W-1:0] address;
	} request_t;

	typedef struct packed {
		logic present;
		logic changed;
		logic full_drop;
		logic [COUNT_W-1:0] entry_count;
	} response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [MODE_W-1:0] mode = '0;
	logic [ADDR_W-1:0] address = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic present, changed, full_drop;
	logic [COUNT_W-1:0] entry_count;

	request_t pending_requests[$];
	response_t expected_responses[$];
	logic slot_used[CAP];
	logic [ADDR_W-1:0] slot_addr[CAP];
	int set_size = 0;
	int failures = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_off = 0;
	logic [ADDR_W-1:0] pool[64];

	ipv4_block_set_table_unit #(.CAPACITY(CAP)) i_dut (.*);

	always #5 clk = ~clk;

	function automatic response_t apply_request(request_t r);
		response_t res;
		int hit;
		int free;
		hit = -1;
		free = -1;
		for (int i = 0; i < CAP; i++) begin
			if (slot_used[i] && slot_addr[i] == r.address && hit < 0)
				hit = i;
			if (!slot_used[i] && free < 0)
				free = i;
		end
		res = '0;
		res.present = (hit >= 0);
		if (r.mode == MODE_ADD && hit < 0) begin
			if (free >= 0) begin
				slot_used[free] = 1'b1;
				slot_addr[free] = r.address;
				set_size++;
				res.changed = 1'b1;
			end else begin
				res.full_drop = 1'b1;
			end
		end else if (r.mode == MODE_REMOVE && hit >= 0) begin
			slot_used[hit] = 1'b0;
			set_size--;
			res.changed = 1'b1;
		end
		res.entry_count = set_size[COUNT_W-1:0];
		return res;
	endfunction

	function automatic request_t make_request(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a);
		request_t r;
		r.mode = m;
		r.address = a;
		return r;
	endfunction

	// Driver: offer the next pending request after a random gap, or at times straight after a handshake
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_responses.push_back(apply_request(make_request(mode, address)));
			send_gap <= $urandom_range(7);
			if (pending_requests.size() == 0 || $urandom_range(3) != 0) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				mode <= pending_requests[0].mode;
				address <= pending_requests[0].address;
				void'(pending_requests.pop_front());
			end
		end else if (!in_valid && arst_n) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (pending_requests.size() > 0) begin
				in_valid <= 1'b1;
				mode <= pending_requests[0].mode;
				address <= pending_requests[0].address;
				void'(pending_requests.pop_front());
			end
		end
	end

	// Monitor: compare each response with the oldest expectation
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_responses.size() == 0) begin
				$error("unexpected response");
				failures++;
			end else begin
				response_t e;
				e = expected_responses.pop_front();
				if (present !== e.present) begin
					$error("present: expected %0d, got %0d", e.present, present);
					failures++;
				end
				if (changed !== e.changed) begin
					$error("changed: expected %0d, got %0d", e.changed, changed);
					failures++;
				end
				if (full_drop !== e.full_drop) begin
					$error("full_drop: expected %0d, got %0d", e.full_drop, full_drop);
					failures++;
				end
				if (entry_count !== e.entry_count) begin
					$error("entry_count: expected %0d, got %0d", e.entry_count, entry_count);
					failures++;
				end
			end
		end
	end

	// Receiver stall: hold off long, or draw a short gap per transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			recv_gap = $urandom_range(7);
			out_ready <= (recv_gap == 0);
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= (recv_gap == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n || hold_off > 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic queue_request(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a);
		pending_requests.push_back(make_request(m, a));
	endtask

	task automatic drain();
		wait (pending_requests.size() == 0 && !in_valid);
		wait (expected_responses.size() == 0);
	endtask

	function automatic logic [MODE_W-1:0] random_mode();
		int p;
		p = $urandom_range(99);
		if (p < 40) return MODE_ADD;
		if (p < 65) return MODE_REMOVE;
		if (p < 95) return MODE_CHECK;
		return MODE_SPARE;
	endfunction

	initial begin
		logic [ADDR_W-1:0] a;
		for (int i = 0; i < CAP; i++) slot_used[i] = 1'b0;
		for (int i = 0; i < 64; i++) pool[i] = $urandom();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every mode, duplicates, absent removes, unused mode
		queue_request(MODE_CHECK, 32'h0000_0000);
		queue_request(MODE_REMOVE, 32'hFFFF_FFFF);
		queue_request(MODE_ADD, 32'h0000_0000);
		queue_request(MODE_ADD, 32'hFFFF_FFFF);
		queue_request(MODE_ADD, 32'hFFFF_FFFF);
		queue_request(MODE_CHECK, 32'hFFFF_FFFF);
		queue_request(MODE_SPARE, 32'h0000_0000);
		queue_request(MODE_SPARE, 32'h5555_5555);
		queue_request(MODE_ADD, 32'hAAAA_AAAA);
		queue_request(MODE_ADD, 32'h5555_5555);
		queue_request(MODE_REMOVE, 32'h0000_0000);
		queue_request(MODE_CHECK, 32'h0000_0000);
		queue_request(MODE_ADD, 32'h0000_0001);
		queue_request(MODE_REMOVE, 32'h8000_0000);
		queue_request(MODE_REMOVE, 32'hAAAA_AAAA);
		drain();

		// Start filling the table while the receiver holds off, then overflow it
		hold_off = 4 * LATENCY;
		for (int i = 0; i < CAP + 6; i++) queue_request(MODE_ADD, 32'hC0A8_0000 + i);
		queue_request(MODE_CHECK, 32'hC0A8_0000);
		queue_request(MODE_REMOVE, 32'hC0A8_0010);
		queue_request(MODE_ADD, 32'hDEAD_BEEF);
		queue_request(MODE_ADD, 32'hDEAD_BEF0);
		drain();

		// Remove the filled addresses again
		for (int i = 0; i < CAP + 6; i++) queue_request(MODE_REMOVE, 32'hC0A8_0000 + i);
		drain();

		// Random: a small pool of addresses so hits are common
		for (int i = 0; i < 260; i++) begin
			a = ($urandom_range(9) == 0) ? $urandom() : pool[$urandom_range(63)];
			queue_request(random_mode(), a);
			if (i == 130) begin
				wait (pending_requests.size() == 0);
				drain();
			end
		end
		drain();
		repeat (2 * LATENCY) @(posedge clk);
		if (failures == 0 && expected_responses.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ----- sim.f -----
hw/rtl/ipbst_pkg.sv
hw/rtl/ipbst_ram.sv
hw/rtl/ipv4_block_set_table_unit.sv
verif/tb.sv
